FILE: src/kmer_histogram_counter_macros.svh
`ifndef KMER_HISTOGRAM_COUNTER_MACROS_SVH
`define KMER_HISTOGRAM_COUNTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KHC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmer histogram check failed");

// Next-cycle implication.
`define KHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmer histogram check failed");

`endif

FILE: src/kmc_pkg.sv
package kmc_pkg;

  localparam int MAX_K_DEF       = 8;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;

  localparam int KLEN_W     = 4;
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int READ_IDX_W = 15;
  localparam int OUT_W      = 32;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd4;
  localparam logic [KLEN_W-1:0] KLEN_MIN   = 4'd2;

  localparam logic [CMD_W-1:0] CMD_BASE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EOS  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [CHAR_W-1:0] CHR_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CHR_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CHR_G_UP = 8'h47;
  localparam logic [CHAR_W-1:0] CHR_G_LO = 8'h67;
  localparam logic [CHAR_W-1:0] CHR_C_UP = 8'h43;
  localparam logic [CHAR_W-1:0] CHR_C_LO = 8'h63;
  localparam logic [CHAR_W-1:0] CHR_T_UP = 8'h54;
  localparam logic [CHAR_W-1:0] CHR_T_LO = 8'h74;

  localparam logic [1:0] DIG_A = 2'd0;
  localparam logic [1:0] DIG_G = 2'd1;
  localparam logic [1:0] DIG_C = 2'd2;
  localparam logic [1:0] DIG_T = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] digit;
  } digit_t;

  // Queue entry control: an update of one entry, or a read-and-clear.
  typedef struct packed {
    logic is_read;
    logic clear_total;
  } op_ctl_t;

  localparam int OP_CTL_W = $bits(op_ctl_t);

  function automatic digit_t base_digit(input logic [CHAR_W-1:0] c);
    digit_t d;
    d.valid = 1'b1;
    d.digit = DIG_A;
    unique case (c) inside
      CHR_A_UP, CHR_A_LO: d.digit = DIG_A;
      CHR_G_UP, CHR_G_LO: d.digit = DIG_G;
      CHR_C_UP, CHR_C_LO: d.digit = DIG_C;
      CHR_T_UP, CHR_T_LO: d.digit = DIG_T;
      default:            d.valid = 1'b0;
    endcase
    return d;
  endfunction

endpackage

FILE: src/kmc_queue.sv
module kmc_queue #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  logic do_push;
  logic do_pop;

  assign empty   = (fill == '0);
  assign full    = (fill == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: src/kmc_front.sv
module kmc_front #(
  parameter int MAX_K = kmc_pkg::MAX_K_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [kmc_pkg::KLEN_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kmc_pkg::CMD_W-1:0]       cmd,
  input  logic [kmc_pkg::CHAR_W-1:0]      base_char,
  input  logic [kmc_pkg::READ_IDX_W-1:0]  read_index,
  input  logic                            clear_total,
  input  logic                            enable,
  input  logic                            q_full,
  output logic                            push,
  output kmc_pkg::op_ctl_t                push_ctl,
  output logic [2*MAX_K-2:0]              push_idx
);

  localparam int WIN_W  = 2 * MAX_K;
  localparam int ADDR_W = 2 * MAX_K - 1;
  localparam int RUN_W  = $clog2(MAX_K + 1);

  logic [kmc_pkg::KLEN_W-1:0] kmer_length;
  logic [WIN_W-1:0]           window;
  logic [WIN_W-1:0]           window_next;
  logic [RUN_W-1:0]           run;
  logic [RUN_W-1:0]           run_next;

  logic                       accept;
  kmc_pkg::digit_t            dg;
  logic [kmc_pkg::KLEN_W-1:0] k_eff;
  logic [WIN_W-1:0]           win_shift;
  logic [RUN_W-1:0]           run_inc;
  logic [WIN_W-1:0]           kmask;
  logic                       lead_hi;
  logic [WIN_W-1:0]           kmer;
  logic                       full_run;

  assign in_ready = enable && !q_full;
  assign accept   = in_valid && in_ready;
  assign dg       = kmc_pkg::base_digit(base_char);

  always_comb begin
    if (kmer_length < kmc_pkg::KLEN_MIN) begin
      k_eff = kmc_pkg::KLEN_MIN;
    end else if (kmer_length > kmc_pkg::KLEN_W'(MAX_K)) begin
      k_eff = kmc_pkg::KLEN_W'(MAX_K);
    end else begin
      k_eff = kmer_length;
    end
  end

  assign win_shift = {window[WIN_W-3:0], dg.digit};
  assign run_inc   = (run < RUN_W'(MAX_K)) ? run + 1'b1 : run;
  assign full_run  = (kmc_pkg::KLEN_W'(run_inc) >= k_eff);

  // Mask of the 2k low bits, and the high bit of the oldest digit in the k-mer.
  always_comb begin
    kmask   = '0;
    lead_hi = 1'b0;
    for (int i = 0; i < WIN_W; i++) begin
      kmask[i] = (5'(i) < {1'b0, k_eff}  + {1'b0, k_eff});
    end
    for (int j = 0; j < MAX_K; j++) begin
      if (kmc_pkg::KLEN_W'(j) == k_eff - 1'b1) begin
        lead_hi = win_shift[2*j+1];
      end
    end
  end

  // Leading C or T: complement every digit so the index drops below 2^(2k-1).
  assign kmer = lead_hi ? ((win_shift & kmask) ^ kmask) : (win_shift & kmask);

  always_comb begin
    window_next          = window;
    run_next             = run;
    push                 = 1'b0;
    push_ctl.is_read     = 1'b0;
    push_ctl.clear_total = 1'b0;
    push_idx             = kmer[ADDR_W-1:0];
    if (accept) begin
      unique case (cmd)
        kmc_pkg::CMD_BASE: begin
          if (dg.valid) begin
            window_next = win_shift;
            run_next    = run_inc;
            push        = full_run;
          end else begin
            window_next = '0;
            run_next    = '0;
          end
        end
        kmc_pkg::CMD_EOS: begin
          window_next = '0;
          run_next    = '0;
        end
        kmc_pkg::CMD_READ: begin
          push                 = 1'b1;
          push_ctl.is_read     = 1'b1;
          push_ctl.clear_total = clear_total;
          push_idx             = ADDR_W'(read_index);
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= kmc_pkg::KLEN_RESET;
      window      <= '0;
      run         <= '0;
    end else begin
      if (cfg_valid) begin
        kmer_length <= cfg_data;
      end
      window <= window_next;
      run    <= run_next;
    end
  end

endmodule

FILE: src/kmc_back.sv
module kmc_back #(
  parameter int MAX_K       = kmc_pkg::MAX_K_DEF,
  parameter int COUNT_WIDTH = kmc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  kmc_pkg::op_ctl_t           q_ctl,
  input  logic [2*MAX_K-2:0]         q_idx,
  output logic                       pop,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kmc_pkg::OUT_W-1:0]  entry_count,
  output logic [kmc_pkg::OUT_W-1:0]  total_count
);

  localparam int ADDR_W = 2 * MAX_K - 1;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int OUT_W  = kmc_pkg::OUT_W;

  logic [COUNT_WIDTH-1:0] table_mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rdata;

  logic [ADDR_W-1:0]      clr_addr;

  logic                   s1_valid;
  kmc_pkg::op_ctl_t       s1_ctl;
  logic [ADDR_W-1:0]      s1_idx;

  logic                   wq_valid;
  logic [ADDR_W-1:0]      wq_addr;
  logic [COUNT_WIDTH-1:0] wq_data;

  logic [COUNT_WIDTH-1:0] total;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] new_val;
  logic [OUT_W-1:0]       ent_sat;
  logic [OUT_W-1:0]       tot_sat;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  // Two-entry result buffer
  logic [OUT_W-1:0]       ob_ent [2];
  logic [OUT_W-1:0]       ob_tot [2];
  logic                   ob_wr;
  logic                   ob_rd;
  logic [1:0]             ob_cnt;
  logic [1:0]             ob_fut;
  logic                   ob_push;
  logic                   ob_pop;
  logic                   room;

  assign out_valid   = (ob_cnt != 2'd0);
  assign ob_pop      = out_valid && out_ready;
  assign entry_count = ob_ent[ob_rd];
  assign total_count = ob_tot[ob_rd];

  // A read may only leave the queue if its result is sure of a buffer slot.
  assign ob_fut = ob_cnt - {1'b0, ob_pop} + {1'b0, s1_valid && s1_ctl.is_read};
  assign room   = (ob_fut <= 2'd1);
  assign pop    = !busy && !q_empty && (!q_ctl.is_read || room);

  // Last cycle's write has not reached the read port yet: take it from here.
  assign cur     = (wq_valid && wq_addr == s1_idx) ? wq_data : rdata;
  assign new_val = s1_ctl.is_read ? '0 : ((&cur) ? cur : cur + 1'b1);
  assign ob_push = s1_valid && s1_ctl.is_read;

  generate
    if (COUNT_WIDTH > OUT_W) begin : g_clip
      assign ent_sat = (|cur[COUNT_WIDTH-1:OUT_W])   ? '1 : cur[OUT_W-1:0];
      assign tot_sat = (|total[COUNT_WIDTH-1:OUT_W]) ? '1 : total[OUT_W-1:0];
    end else begin : g_ext
      assign ent_sat = OUT_W'(cur);
      assign tot_sat = OUT_W'(total);
    end
  endgenerate

  always_comb begin
    if (busy) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_valid;
      mem_waddr = s1_idx;
      mem_wdata = new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= table_mem[q_idx];
  end

  always_ff @(posedge clk) begin
    s1_ctl  <= q_ctl;
    s1_idx  <= q_idx;
    wq_addr <= s1_idx;
    wq_data <= new_val;
    if (ob_push) begin
      ob_ent[ob_wr] <= ent_sat;
      ob_tot[ob_wr] <= tot_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
      s1_valid <= 1'b0;
      wq_valid <= 1'b0;
      total    <= '0;
      ob_wr    <= 1'b0;
      ob_rd    <= 1'b0;
      ob_cnt   <= 2'd0;
    end else begin
      if (busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (&clr_addr) begin
          busy <= 1'b0;
        end
      end
      s1_valid <= pop;
      wq_valid <= s1_valid;
      if (s1_valid) begin
        if (!s1_ctl.is_read) begin
          total <= (&total) ? total : total + 1'b1;
        end else if (s1_ctl.clear_total) begin
          total <= '0;
        end
      end
      if (ob_push) begin
        ob_wr <= ~ob_wr;
      end
      if (ob_pop) begin
        ob_rd <= ~ob_rd;
      end
      ob_cnt <= ob_cnt + {1'b0, ob_push} - {1'b0, ob_pop};
    end
  end

endmodule

FILE: src/kmer_histogram_counter.sv
// Canonical k-mer counter. Feed one beat per cycle on the input channel: a base
// character (A/G/C/T, either case; anything else restarts the window), an end of
// sequence, or a read-and-clear of one count table entry. Base and end beats give
// no result; a read beat gives one result beat carrying the entry's count and the
// running total, after which the entry (and the total, if asked) is zeroed. The
// sustained rate is one beat per clock for every command while results are taken,
// set by the table's read-modify-write pipeline with write forwarding. After reset
// the count table is swept to zero, one entry per cycle, over all 2^(2*MAX_K-1)
// entries (32768 at MAX_K = 8), during which in_ready stays low. kmer_length writes
// are always taken (cfg_ready is tied high) and must only be made while no read
// result is pending.
module kmer_histogram_counter #(
  parameter int MAX_K       = kmc_pkg::MAX_K_DEF,
  parameter int COUNT_WIDTH = kmc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kmc_pkg::KLEN_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kmc_pkg::CMD_W-1:0]       cmd,
  input  logic [kmc_pkg::CHAR_W-1:0]      base_char,
  input  logic [kmc_pkg::READ_IDX_W-1:0]  read_index,
  input  logic                            clear_total,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kmc_pkg::OUT_W-1:0]       entry_count,
  output logic [kmc_pkg::OUT_W-1:0]       total_count
);

  localparam int ADDR_W = 2 * MAX_K - 1;
  localparam int Q_W    = kmc_pkg::OP_CTL_W + ADDR_W;

  logic              busy;
  logic              push;
  kmc_pkg::op_ctl_t  push_ctl;
  logic [ADDR_W-1:0] push_idx;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  logic [Q_W-1:0]    q_head;
  kmc_pkg::op_ctl_t  q_ctl;
  logic [ADDR_W-1:0] q_idx;

  assign cfg_ready = 1'b1;
  assign q_ctl     = q_head[Q_W-1:ADDR_W];
  assign q_idx     = q_head[ADDR_W-1:0];

  kmc_front #(
    .MAX_K (MAX_K)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .base_char   (base_char),
    .read_index  (read_index),
    .clear_total (clear_total),
    .enable      (!busy),
    .q_full      (q_full),
    .push        (push),
    .push_ctl    (push_ctl),
    .push_idx    (push_idx)
  );

  kmc_queue #(
    .WIDTH (Q_W),
    .DEPTH (kmc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ctl, push_idx}),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  kmc_back #(
    .MAX_K       (MAX_K),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_ctl       (q_ctl),
    .q_idx       (q_idx),
    .pop         (pop),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .entry_count (entry_count),
    .total_count (total_count)
  );

endmodule

FILE: src/kmc_checker.sv
`include "kmer_histogram_counter_macros.svh"

module kmc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [kmc_pkg::CMD_W-1:0]       cmd,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [kmc_pkg::OUT_W-1:0]       entry_count,
  input logic [kmc_pkg::OUT_W-1:0]       total_count
);

  logic [3:0] pending;
  logic       rd_in;
  logic       rd_out;

  assign rd_in  = in_valid && in_ready && (cmd == kmc_pkg::CMD_READ);
  assign rd_out = out_valid && out_ready;

  // Read beats taken but not yet answered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {3'd0, rd_in} - {3'd0, rd_out};
    end
  end

  `KHC_ASSERT_NOW(a_no_stray_result, out_valid, pending != 4'd0)
  `KHC_ASSERT_NOW(a_cfg_never_stalls, cfg_valid, cfg_ready)
  `KHC_ASSERT_NOW(a_sweep_after_reset, $fell(rst), !in_ready)
  `KHC_ASSERT_NEXT(a_result_held, out_valid && !out_ready,
                   out_valid && $stable(entry_count) && $stable(total_count))

endmodule

bind kmer_histogram_counter kmc_checker u_checker (.*);
